// ===== sv/lidar_scan_near_segmenter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// lidar_scan_near_segmenter_unit_defines.svh
// Assertion macros shared by the segmenter checker.
// ----------------------------------------------------------------------------
`ifndef LIDAR_SCAN_NEAR_SEGMENTER_UNIT_DEFINES_SVH
`define LIDAR_SCAN_NEAR_SEGMENTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LSNS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LSNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lsns_pkg.sv =====
// ----------------------------------------------------------------------------
// lsns_pkg
// Types and constants of the near-object lidar scan segmenter.
// ----------------------------------------------------------------------------
package lsns_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  localparam int RANGE_W  = 16;
  localparam int CIDX_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT = 2'd1;

  localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST = 16'd1000;
  localparam logic [RANGE_W-1:0] JUMP_LIMIT_RST = 16'd200;

  // result queue
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic                last;
    logic [RANGE_W-1:0]  center_range;
    logic [CIDX_W-1:0]   center_index;
  } result_t;

endpackage

// ===== sv/lidar_scan_near_segmenter_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_scan_near_segmenter_unit
// Near-object segmentation of a streamed lidar scan by range jumps.
// ----------------------------------------------------------------------------
// One range sample is taken per cycle if input is not paused; results are
// registered in the read stage, then the result queue. Each sample is written
// to the range line store when it is taken, and the segment center(s) it closes
// are read from the store's two read ports on that same edge, with the sample
// itself forwarded when the center is the current index. A sample that closes
// one segment by a jump and another by scan end gives two results, which leave
// one after the other; a four-entry result queue absorbs them. Input pauses
// when queued and read-stage results exceed two, as when results are not taken
// or closing items bring them faster than one per cycle. The store needs no
// clearing after reset: a center always lies at or before the current sample
// of the current scan. Samples beyond MAX_POINTS in one scan are dropped.
// ----------------------------------------------------------------------------
module lidar_scan_near_segmenter_unit #(
  parameter int MAX_POINTS = lsns_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [lsns_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lsns_pkg::CFG_W-1:0]     cfg_wdata_i,
  // samples
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lsns_pkg::S_DATA_W-1:0]  s_axis_tdata,   // [15:0] range_mm
  input  logic                           s_axis_tlast,   // last_point
  // results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lsns_pkg::M_DATA_W-1:0]  m_axis_tdata,   // [9:0] center_index,
                                                         // [25:10] center_range
  output logic                           m_axis_tlast    // last_result
);
  import lsns_pkg::*;

  localparam int IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SW  = $clog2(MAX_POINTS + 1);
  localparam int XW  = (SW > CIDX_W) ? SW : CIDX_W;
  localparam int QPW = $clog2(OQ_DEPTH);
  localparam int QCW = $clog2(OQ_DEPTH + 1);
  localparam logic [SW-1:0] MAX_IDX = SW'(MAX_POINTS);

  function automatic logic [CIDX_W-1:0] to_cidx(logic [SW-1:0] c);
    logic [XW-1:0] e;
    e = XW'(c);
    return e[CIDX_W-1:0];
  endfunction

  // configuration registers
  logic [RANGE_W-1:0] near_limit_q, jump_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_limit_q <= NEAR_LIMIT_RST;
      jump_limit_q <= JUMP_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_NEAR_LIMIT: near_limit_q <= cfg_wdata_i;
        CFG_JUMP_LIMIT: jump_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // scan state
  logic [SW-1:0]      sample_index_q, sample_index_d;
  logic               seg_open_q, seg_open_d;
  logic [SW-1:0]      seg_start_q, seg_start_d;
  logic [RANGE_W-1:0] prev_range_q, prev_range_d;

  // read stage
  logic [1:0]         s1_n_q, s1_n_d;
  logic [CIDX_W-1:0]  s1_cidx_a_q, s1_cidx_b_q;
  logic               s1_fwd_a_q, s1_fwd_b_q;
  logic [RANGE_W-1:0] s1_range_q;
  logic [RANGE_W-1:0] rd_a_q, rd_b_q;

  // result queue
  result_t            oq_q [OQ_DEPTH];
  logic [QPW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]     count_q;

  logic [RANGE_W-1:0] range_mem [MAX_POINTS];

  logic               accept;
  logic [RANGE_W-1:0] r;
  logic               in_range, jump, opens, open_mid, end_res;
  logic [RANGE_W-1:0] diff;
  logic [SW-1:0]      end_idx, c_jump, c_end, c_a;
  logic [1:0]         n_res;

  assign s_axis_tready = (4'(count_q) + 4'(s1_n_q) + 4'd2) <= 4'(OQ_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign r             = s_axis_tdata[RANGE_W-1:0];

  always_comb begin
    in_range = sample_index_q != MAX_IDX;
    diff     = (r > prev_range_q) ? (r - prev_range_q) : (prev_range_q - r);
    jump     = in_range && seg_open_q && (diff > jump_limit_q);
    open_mid = in_range ? (seg_open_q && !jump) : seg_open_q;
    opens    = in_range && !open_mid && (r != '0) && (r < near_limit_q);
    seg_open_d  = open_mid || opens;
    seg_start_d = opens ? sample_index_q : seg_start_q;
    end_idx  = in_range ? (sample_index_q + SW'(1)) : sample_index_q;
    c_jump   = seg_start_q + ((sample_index_q - seg_start_q) >> 1);
    c_end    = seg_start_d + ((end_idx - seg_start_d) >> 1);
    end_res  = s_axis_tlast && seg_open_d;
    n_res    = 2'(jump) + 2'(end_res);
    c_a      = jump ? c_jump : c_end;
    s1_n_d   = accept ? n_res : 2'd0;

    sample_index_d = end_idx;
    prev_range_d   = in_range ? r : prev_range_q;
    if (s_axis_tlast) begin
      sample_index_d = '0;
      seg_open_d     = 1'b0;
      seg_start_d    = '0;
      prev_range_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_index_q <= '0;
      seg_open_q     <= 1'b0;
      seg_start_q    <= '0;
      prev_range_q   <= '0;
      s1_n_q         <= 2'd0;
    end else begin
      s1_n_q <= s1_n_d;
      if (accept) begin
        sample_index_q <= sample_index_d;
        seg_open_q     <= seg_open_d;
        seg_start_q    <= seg_start_d;
        prev_range_q   <= prev_range_d;
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cidx_a_q <= to_cidx(c_a);
      s1_cidx_b_q <= to_cidx(c_end);
      // center at the sample being written: take it from the input
      s1_fwd_a_q  <= in_range && (c_a == sample_index_q);
      s1_fwd_b_q  <= in_range && (c_end == sample_index_q);
      s1_range_q  <= r;
    end
  end

  // line store: write the sample, read both centers (old data on collision)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (in_range) begin
        range_mem[sample_index_q[IW-1:0]] <= r;
      end
      rd_a_q <= range_mem[c_a[IW-1:0]];
      rd_b_q <= range_mem[c_end[IW-1:0]];
    end
  end

  result_t res_a, res_b;
  logic    pop;
  logic [QCW-1:0] push_n;

  always_comb begin
    res_a.center_index = s1_cidx_a_q;
    res_a.center_range = s1_fwd_a_q ? s1_range_q : rd_a_q;
    res_a.last         = s1_n_q == 2'd1;
    res_b.center_index = s1_cidx_b_q;
    res_b.center_range = s1_fwd_b_q ? s1_range_q : rd_b_q;
    res_b.last         = 1'b1;
    push_n             = QCW'(s1_n_q);
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPW'(s1_n_q);
      rd_ptr_q <= rd_ptr_q + QPW'(pop);
      count_q  <= count_q + push_n - QCW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_n_q != 2'd0) begin
      oq_q[wr_ptr_q] <= res_a;
    end
    if (s1_n_q == 2'd2) begin
      oq_q[wr_ptr_q + QPW'(1)] <= res_b;
    end
  end

  result_t head;
  assign head          = oq_q[rd_ptr_q];
  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tdata  = M_DATA_W'({head.center_range, head.center_index});
  assign m_axis_tlast  = head.last;

endmodule

// ===== sv/lsns_checker.sv =====
// ----------------------------------------------------------------------------
// lsns_checker
// Port-level checks of the near-object lidar scan segmenter.
// ----------------------------------------------------------------------------
`include "lidar_scan_near_segmenter_unit_defines.svh"

module lsns_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lsns_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input logic                           m_axis_tlast
);
  import lsns_pkg::*;

  // a stalled result keeps its payload
  `LSNS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "result changed while stalled")

  // the second result of an item is queued together with the first
  `LSNS_ASSERT_NEXT(a_pair_follows, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid,
    "second result of an item missing")

  // input only stalls while results are waiting
  `LSNS_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid,
    "input stalled with no result pending")

endmodule

bind lidar_scan_near_segmenter_unit lsns_checker u_lsns_checker (.*);
